[hdl/vpt_pkg.sv]
// vpt_pkg: constants, opcodes, record types and address decode
// shared by the vertex provenance tracker modules; no dependencies
package vpt_pkg;

  localparam int RAM_WORDS     = 524288;
  localparam int SCRATCH_WORDS = 256;
  localparam int FIFO_SLOTS    = 32;
  localparam int BUFFER_SLOTS  = 16;

  localparam int MEM_WORDS = RAM_WORDS + SCRATCH_WORDS;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int FIFO_AW   = (FIFO_SLOTS > 1) ? $clog2(FIFO_SLOTS) : 1;
  localparam int BUF_AW    = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;

  localparam logic [3:0] OP_COP_MOVE = 4'd0;
  localparam logic [3:0] OP_SHIFT    = 4'd1;
  localparam logic [3:0] OP_COPY     = 4'd2;
  localparam logic [3:0] OP_OBSERVE  = 4'd3;
  localparam logic [3:0] OP_LOAD     = 4'd4;
  localparam logic [3:0] OP_MEM_WR   = 4'd5;
  localparam logic [3:0] OP_STORE    = 4'd6;
  localparam logic [3:0] OP_FIFO_WR  = 4'd7;
  localparam logic [3:0] OP_CB_COPY  = 4'd8;
  localparam logic [3:0] OP_RECOVER  = 4'd9;

  localparam logic [31:0] ADDR_MASK    = 32'h001ffffc;
  localparam logic [31:0] SCRATCH_BASE = 32'h1f800000;
  localparam logic [31:0] SCRATCH_END  = 32'h1f800400;
  localparam logic [7:0]  SEG_KUSEG    = 8'h00;
  localparam logic [7:0]  SEG_KSEG0    = 8'h80;
  localparam logic [7:0]  SEG_KSEG1    = 8'ha0;
  localparam logic [5:0]  PRIM_LW      = 6'h23;
  localparam logic [5:0]  PRIM_SW      = 6'h2b;
  localparam logic [4:0]  SHIFT_AMT    = 5'd5;

  localparam logic [1:0] STG_PROJ    = 2'd1;
  localparam logic [1:0] STG_SHIFTED = 2'd2;
  localparam logic [1:0] STG_REST    = 2'd3;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] v;
    logic [1:0]  stage;
    logic        w;
  } rec_t;

  typedef struct packed {
    logic vld;
    rec_t rec;
  } mem_word_t;

  typedef struct packed {
    logic              hit;
    logic [MEM_AW-1:0] idx;
  } map_t;

  function automatic logic finite_bits(input logic [31:0] f);
    return f[30:23] != 8'hff;
  endfunction

  function automatic map_t map_addr(input logic [31:0] a);
    map_t        m;
    logic [31:0] word;
    logic [31:0] soff;
    word  = (a & ADDR_MASK) >> 2;
    soff  = (a - SCRATCH_BASE) >> 2;
    m.hit = 1'b0;
    m.idx = '0;
    if (a[31:24] == SEG_KUSEG || a[31:24] == SEG_KSEG0 || a[31:24] == SEG_KSEG1) begin
      m.hit = 1'b1;
      m.idx = MEM_AW'(word % RAM_WORDS);
    end else if (a >= SCRATCH_BASE && a < SCRATCH_END) begin
      m.hit = 1'b1;
      m.idx = MEM_AW'(RAM_WORDS) + MEM_AW'(soff);
    end
    return m;
  endfunction

endpackage

[hdl/vpt_ram.sv]
// vpt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module vpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/vertex_provenance_tracker.sv]
// vertex_provenance_tracker: top level, event sequencer around four record rams
// depends on vpt_pkg and vpt_ram
// the ram reads are registered on accept, then the exec state modifies, writes back and
// registers the result, holding while the output stalls; s_tready is low until it is done
// reset: flop valid bits clear at once, then a clearing pass writes every
// memory word (MEM_WORDS = 524544 words) while s_tready stays low
module vertex_provenance_tracker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // instr, addr, value, second_value, arithmetic, index_a, index_b,
  // precise_x, precise_y, precise_z, precise_flags, zero pad
  input  logic [239:0] s_tdata,
  // opcode
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vertex_x, vertex_y, vertex_z, w_valid, zero pad
  output logic [103:0] m_tdata,
  // found
  output logic [0:0]   m_tuser
);
  import vpt_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [MEM_AW-1:0] clr_cnt;

  // latched item
  logic [3:0]  op;
  logic [31:0] instr;
  logic [31:0] value;
  logic [31:0] value2;
  logic        arith;
  logic [4:0]  ia;
  logic [4:0]  ib;
  logic [31:0] px, py, pz;
  logic [3:0]  pf;
  map_t        maddr;

  logic [31:0]             reg_vld;
  logic [31:0]             touched;
  logic [FIFO_SLOTS-1:0]   fifo_vld;
  logic [BUFFER_SLOTS-1:0] buf_vld;

  logic accept, out_free, go;
  logic [31:0] in_instr, in_addr;
  logic [4:0]  in_ia, in_ib;
  logic [4:0]  rt, rd, sa;
  logic [5:0]  prim;

  rec_t      reg_rd, fifo_rd, buf_rd;
  mem_word_t mem_rd;

  // reg file update
  logic       reg_upd, reg_nv;
  logic [4:0] reg_dst;
  rec_t       reg_wd;
  logic [4:0] reg_ra;
  // memory update
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  mem_word_t         mem_wd;
  // fifo and buffer updates
  logic   fifo_upd, fifo_nv;
  rec_t   fifo_wd;
  logic   buf_upd, buf_nv;
  rec_t   buf_wd;
  logic   found;
  rec_t   res;

  assign in_instr = s_tdata[31:0];
  assign in_addr  = s_tdata[63:32];
  assign in_ia    = s_tdata[133:129];
  assign in_ib    = s_tdata[138:134];

  assign rt   = instr[20:16];
  assign rd   = instr[15:11];
  assign sa   = instr[10:6];
  assign prim = instr[31:26];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign go       = (state == ST_EXEC) && out_free;

  always_comb begin
    if (s_tuser == OP_COPY) begin
      reg_ra = in_ib;
    end else begin
      reg_ra = in_instr[20:16];
    end
  end

  vpt_ram #(.WIDTH($bits(rec_t)), .DEPTH(32)) u_reg_ram (
    .clk   (clk),
    .we    (go && reg_upd && reg_nv),
    .waddr (reg_dst),
    .wdata (reg_wd),
    .re    (accept),
    .raddr (reg_ra),
    .rdata (reg_rd)
  );

  vpt_ram #(.WIDTH($bits(mem_word_t)), .DEPTH(MEM_WORDS)) u_mem_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (accept),
    .raddr (map_addr(in_addr).idx),
    .rdata (mem_rd)
  );

  vpt_ram #(.WIDTH($bits(rec_t)), .DEPTH(FIFO_SLOTS)) u_fifo_ram (
    .clk   (clk),
    .we    (go && fifo_upd && fifo_nv),
    .waddr (ia[FIFO_AW-1:0]),
    .wdata (fifo_wd),
    .re    (accept),
    .raddr (in_ib[FIFO_AW-1:0]),
    .rdata (fifo_rd)
  );

  vpt_ram #(.WIDTH($bits(rec_t)), .DEPTH(BUFFER_SLOTS)) u_buf_ram (
    .clk   (clk),
    .we    (go && buf_upd && buf_nv),
    .waddr (ia[BUF_AW-1:0]),
    .wdata (buf_wd),
    .re    (accept),
    .raddr (in_ia[BUF_AW-1:0]),
    .rdata (buf_rd)
  );

  // event decode and record update
  always_comb begin
    reg_upd  = 1'b0;
    reg_nv   = 1'b0;
    reg_dst  = rt;
    reg_wd   = reg_rd;
    mem_we   = 1'b0;
    mem_wa   = maddr.idx;
    mem_wd   = '0;
    fifo_upd = 1'b0;
    fifo_nv  = 1'b0;
    fifo_wd  = mem_rd.rec;
    buf_upd  = 1'b0;
    buf_nv   = 1'b0;
    buf_wd   = fifo_rd;
    found    = 1'b0;
    res      = '0;
    case (op)
      OP_COP_MOVE: begin
        reg_upd = (rt != 5'd0);
        reg_nv  = pf[0] && (value2 == value) && (pf[2:1] == 2'b11) &&
                  finite_bits(px) && finite_bits(py) && finite_bits(pz);
        reg_wd  = '{x: px, y: py, z: pz, v: value, stage: STG_PROJ, w: pf[3]};
      end
      OP_SHIFT: begin
        reg_upd = (rd != 5'd0);
        reg_dst = rd;
        reg_nv  = reg_vld[rt] && (sa == SHIFT_AMT) && (reg_rd.v == value2) &&
                  ((!arith && reg_rd.stage == STG_PROJ) ||
                   (arith && rd == rt && reg_rd.stage == STG_SHIFTED));
        reg_wd.v     = value;
        reg_wd.stage = arith ? STG_REST : STG_SHIFTED;
      end
      OP_COPY: begin
        reg_upd = (ia != 5'd0);
        reg_dst = ia;
        reg_nv  = (ib != 5'd0) && (value2 == value) && reg_vld[ib] && (reg_rd.v == value2);
      end
      OP_LOAD: begin
        reg_upd = (rt != 5'd0);
        reg_nv  = (prim == PRIM_LW) && maddr.hit && mem_rd.vld && (mem_rd.rec.v == value);
        reg_wd  = mem_rd.rec;
      end
      OP_MEM_WR: begin
        mem_we = go && maddr.hit;
      end
      OP_STORE: begin
        mem_we     = go && maddr.hit;
        mem_wd.vld = (prim == PRIM_SW) && reg_vld[rt] && (reg_rd.v == value);
        mem_wd.rec = reg_rd;
      end
      OP_FIFO_WR: begin
        fifo_upd = ({27'd0, ia} < FIFO_SLOTS);
        fifo_nv  = maddr.hit && mem_rd.vld && (mem_rd.rec.v == value);
      end
      OP_CB_COPY: begin
        buf_upd = ({27'd0, ia} < BUFFER_SLOTS) && ({27'd0, ib} < FIFO_SLOTS);
        buf_nv  = buf_upd && fifo_vld[ib[FIFO_AW-1:0]];
      end
      OP_RECOVER: begin
        if ({27'd0, ia} < BUFFER_SLOTS) begin
          found = buf_vld[ia[BUF_AW-1:0]] && buf_rd.stage[1] && (buf_rd.v == value) &&
                  finite_bits(buf_rd.x) && finite_bits(buf_rd.y) &&
                  finite_bits(buf_rd.z);
        end
        if (found) begin
          res = buf_rd;
        end
      end
      default: begin
      end
    endcase
    // clearing pass owns the memory write port
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
      mem_wd = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == MEM_AW'(MEM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      reg_vld  <= '0;
      touched  <= '0;
      fifo_vld <= '0;
      buf_vld  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (go) begin
        m_tvalid <= 1'b1;
        if (reg_upd) begin
          reg_vld[reg_dst] <= reg_nv;
          touched[reg_dst] <= 1'b1;
        end
        if (op == OP_OBSERVE && ia != 5'd0) begin
          if (!touched[ia]) begin
            reg_vld[ia] <= 1'b0;
          end
          touched[ia] <= 1'b0;
        end
        if (fifo_upd) begin
          fifo_vld[ia[FIFO_AW-1:0]] <= fifo_nv;
        end
        if (buf_upd) begin
          buf_vld[ia[BUF_AW-1:0]] <= buf_nv;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= s_tuser;
      instr  <= in_instr;
      maddr  <= map_addr(in_addr);
      value  <= s_tdata[95:64];
      value2 <= s_tdata[127:96];
      arith  <= s_tdata[128];
      ia     <= in_ia;
      ib     <= in_ib;
      px     <= s_tdata[170:139];
      py     <= s_tdata[202:171];
      pz     <= s_tdata[234:203];
      pf     <= s_tdata[238:235];
    end
    if (go) begin
      m_tdata <= {7'd0, res.w, res.z, res.y, res.x};
      m_tuser <= found;
    end
  end

endmodule

[hdl/vpt_checker.sv]
// vpt_checker: port-level assertions for vertex_provenance_tracker
// depends on nothing but the top-level ports; bound to the top level below
module vpt_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [239:0] s_tdata,
  input logic [3:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [0:0]   m_tuser
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: no accept right after an accept
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted back to back");

  // a miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("nonzero payload on a miss");

  // a hit only returns finite coordinates
  a_hit_finite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[30:23] != 8'hff && m_tdata[62:55] != 8'hff && m_tdata[94:87] != 8'hff)
    else $error("non-finite coordinate on a hit");

endmodule

bind vertex_provenance_tracker vpt_checker u_vpt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[bench/vpt_checker.sv]
// vpt_scoreboard: watches both stream channels of the vertex provenance tracker,
// predicts each result from its own copy of the record stores and compares
// depends on vpt_pkg for record type, opcodes, sizes and address constants
`timescale 1ns / 1ps
module vpt_scoreboard (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [239:0] s_tdata,
  input  logic [3:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic [0:0]   m_tuser,
  output int           errors,
  output int           pending
);
  import vpt_pkg::*;

  typedef struct {
    bit        found;
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
    bit        w;
  } vertex_t;

  rec_t    reg_rec [32];
  bit      reg_ok  [32];
  bit [31:0] touched;
  rec_t    mem_rec [int];
  bit      mem_ok  [int];
  rec_t    fifo_rec [FIFO_SLOTS];
  bit      fifo_ok  [FIFO_SLOTS];
  rec_t    buf_rec  [BUFFER_SLOTS];
  bit      buf_ok   [BUFFER_SLOTS];
  vertex_t vertex_q [$];

  function automatic bit is_finite(bit [31:0] f);
    return f[30:23] != 8'hff;
  endfunction

  // -1 when unmapped
  function automatic int word_index(bit [31:0] a);
    if (a[31:24] == SEG_KUSEG || a[31:24] == SEG_KSEG0 || a[31:24] == SEG_KSEG1)
      return ((a & ADDR_MASK) >> 2) % RAM_WORDS;
    if (a >= SCRATCH_BASE && a < SCRATCH_END)
      return RAM_WORDS + ((a - SCRATCH_BASE) >> 2);
    return -1;
  endfunction

  function automatic bit mem_hit(int idx, bit [31:0] v);
    if (idx < 0 || !mem_ok.exists(idx) || !mem_ok[idx]) return 0;
    return mem_rec[idx].v == v;
  endfunction

  task automatic track_event(input logic [3:0] op, input logic [239:0] d);
    bit [31:0] instr, addr, v, v2, px, py, pz;
    bit        ar;
    bit [4:0]  ia, ib, rt, rd, sa;
    bit [5:0]  prim;
    bit [3:0]  pf;
    rec_t      r;
    bit        ok;
    int        idx;
    vertex_t   e;
    instr = d[31:0];    addr = d[63:32];  v = d[95:64];  v2 = d[127:96];
    ar = d[128];        ia = d[133:129];  ib = d[138:134];
    px = d[170:139];    py = d[202:171];  pz = d[234:203]; pf = d[238:235];
    rt = instr[20:16];  rd = instr[15:11]; sa = instr[10:6]; prim = instr[31:26];
    e = '{0, 0, 0, 0, 0};
    case (op)
      OP_COP_MOVE: if (rt != 0) begin
        touched[rt] = 1; reg_ok[rt] = 0; reg_rec[rt] = '0;
        if (pf[0] && v2 == v && pf[2:1] == 2'b11 && is_finite(px) && is_finite(py)
            && is_finite(pz)) begin
          reg_rec[rt] = '{x: px, y: py, z: pz, v: v, stage: STG_PROJ, w: pf[3]};
          reg_ok[rt] = 1;
        end
      end
      OP_SHIFT: if (rd != 0) begin
        r = reg_rec[rt]; ok = reg_ok[rt];
        touched[rd] = 1; reg_ok[rd] = 0; reg_rec[rd] = '0;
        if (ok && sa == SHIFT_AMT && r.v == v2) begin
          if (!ar && r.stage == STG_PROJ) r.stage = STG_SHIFTED;
          else if (ar && rd == rt && r.stage == STG_SHIFTED) r.stage = STG_REST;
          else ok = 0;
          if (ok) begin
            r.v = v; reg_rec[rd] = r; reg_ok[rd] = 1;
          end
        end
      end
      OP_COPY: if (ia != 0) begin
        r = reg_rec[ib]; ok = reg_ok[ib];
        touched[ia] = 1; reg_ok[ia] = 0; reg_rec[ia] = '0;
        if (ib != 0 && v2 == v && ok && r.v == v2) begin
          reg_rec[ia] = r; reg_ok[ia] = 1;
        end
      end
      OP_OBSERVE: if (ia != 0) begin
        if (!touched[ia]) begin
          reg_ok[ia] = 0; reg_rec[ia] = '0;
        end
        touched[ia] = 0;
      end
      OP_LOAD: if (rt != 0) begin
        touched[rt] = 1; reg_ok[rt] = 0; reg_rec[rt] = '0;
        idx = word_index(addr);
        if (prim == PRIM_LW && mem_hit(idx, v)) begin
          reg_rec[rt] = mem_rec[idx]; reg_ok[rt] = 1;
        end
      end
      OP_MEM_WR: begin
        idx = word_index(addr);
        if (idx >= 0) mem_ok[idx] = 0;
      end
      OP_STORE: begin
        idx = word_index(addr);
        if (idx >= 0) begin
          mem_ok[idx] = 0;
          if (prim == PRIM_SW && reg_ok[rt] && reg_rec[rt].v == v) begin
            mem_rec[idx] = reg_rec[rt]; mem_ok[idx] = 1;
          end
        end
      end
      OP_FIFO_WR: if (ia < FIFO_SLOTS) begin
        fifo_ok[ia] = 0; fifo_rec[ia] = '0;
        idx = word_index(addr);
        if (mem_hit(idx, v)) begin
          fifo_rec[ia] = mem_rec[idx]; fifo_ok[ia] = 1;
        end
      end
      OP_CB_COPY: if (ia < BUFFER_SLOTS && ib < FIFO_SLOTS) begin
        buf_rec[ia] = fifo_rec[ib]; buf_ok[ia] = fifo_ok[ib];
      end
      OP_RECOVER: if (ia < BUFFER_SLOTS) begin
        r = buf_rec[ia];
        if (buf_ok[ia] && (r.stage == STG_SHIFTED || r.stage == STG_REST) && r.v == v
            && is_finite(r.x) && is_finite(r.y) && is_finite(r.z))
          e = '{1, r.x, r.y, r.z, r.w};
      end
      default: ;
    endcase
    vertex_q.push_back(e);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    touched = 0;
    for (int i = 0; i < 32; i++) begin
      reg_rec[i] = '0; reg_ok[i] = 0;
    end
    for (int i = 0; i < FIFO_SLOTS; i++) begin
      fifo_rec[i] = '0; fifo_ok[i] = 0;
    end
    for (int i = 0; i < BUFFER_SLOTS; i++) begin
      buf_rec[i] = '0; buf_ok[i] = 0;
    end
  end

  always @(posedge clk) begin
    vertex_t e;
    bit      bad;
    if (!rst && s_tvalid && s_tready) track_event(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      if (vertex_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        e = vertex_q.pop_front();
        bad = m_tuser[0] !== e.found || m_tdata[31:0] !== e.x || m_tdata[63:32] !== e.y
              || m_tdata[95:64] !== e.z || m_tdata[96] !== e.w;
        if (bad) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch at %0t: exp found=%0d x=%h y=%h z=%h w=%0d,",
                      " got found=%0d x=%h y=%h z=%h w=%0d"},
                     $realtime, e.found, e.x, e.y, e.z, e.w, m_tuser[0],
                     m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[96]);
        end
      end
    end
    pending = vertex_q.size();
  end

endmodule

[bench/tb_vertex_provenance_tracker.sv]
// tb_vertex_provenance_tracker: drives event streams into the tracker with random
// gaps and back-pressure; depends on vpt_pkg, vpt_scoreboard and the tracker rtl
`timescale 1ns / 1ps
module tb_vertex_provenance_tracker;
  import vpt_pkg::*;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] instr, addr, v, v2;
    logic        ar;
    logic [4:0]  ia, ib;
    logic [31:0] px, py, pz;
    logic [3:0]  pf;
  } event_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [239:0] s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [103:0] m_tdata;
  logic [0:0]   m_tuser;
  int           errors, pending;
  int           sent = 0;

  vertex_provenance_tracker dut (.*);
  vpt_scoreboard u_scoreboard (.*);

  always begin
    clk = 1; #10;
    clk = 0; #10;
  end

  function automatic logic [31:0] ins(logic [5:0] prim, logic [4:0] rt, logic [4:0] rd,
                                      logic [4:0] sa);
    return {prim, 5'd0, rt, rd, sa, 6'd0};
  endfunction

  function automatic logic [31:0] fin_float();
    logic [31:0] f;
    f = $urandom;
    if (f[30:23] == 8'hff) f[23] = 0;
    return f;
  endfunction

  function automatic event_t blank(logic [3:0] op);
    event_t e;
    e = '{op, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    return e;
  endfunction

  function automatic event_t noise();
    event_t e;
    e = '{4'($urandom), $urandom, $urandom, $urandom, $urandom, 1'($urandom),
          5'($urandom), 5'($urandom), $urandom, $urandom, $urandom, 4'($urandom)};
    return e;
  endfunction

  // mostly a small pool of ram words under all three segments plus scratch
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    case ($urandom_range(9))
      0, 1, 2: a = {SEG_KUSEG, 3'($urandom), 11'd0, 8'($urandom_range(15)), 2'($urandom)};
      3, 4:    a = {SEG_KSEG0, 3'($urandom), 11'd0, 8'($urandom_range(15)), 2'($urandom)};
      5, 6:    a = {SEG_KSEG1, 24'($urandom_range(15) << 2)} | 32'($urandom_range(3));
      7, 8:    a = SCRATCH_BASE + 32'($urandom_range(32'h3ff));
      default: a = $urandom_range(1) ? SCRATCH_END : $urandom;
    endcase
    return a;
  endfunction

  task automatic send(event_t e);
    if (!(sent >= 500 && sent < 800) && $urandom_range(99) < 6) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= e.op;
    s_tdata  <= {1'b0, e.pf, e.pz, e.py, e.px, e.ib, e.ia, e.ar, e.v2, e.v, e.addr, e.instr};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // one occasionally corrupted step of a vertex's journey
  task automatic step(event_t e);
    event_t n;
    n = noise();
    case ($urandom_range(29))
      0: e.v = n.v;
      1: e.instr = n.instr;
      2: e.ia = n.ia;
      3: e.v2 = n.v2;
      default: ;
    endcase
    send(e);
  endtask

  task automatic vertex_chain();
    event_t e;
    logic [31:0] v, a;
    logic [4:0]  r0, r1, r2;
    logic [4:0]  f, b;
    v = $urandom; a = pick_addr();
    r0 = 5'($urandom_range(1, 31)); r1 = 5'($urandom_range(1, 31));
    r2 = 5'($urandom_range(1, 31));
    f = 5'($urandom); b = $urandom_range(9) == 0 ? 5'($urandom) : 5'($urandom_range(15));
    e = blank(OP_COP_MOVE); e.instr = ins(6'($urandom), r0, 5'($urandom), 5'($urandom));
    e.v = v; e.v2 = v; e.px = fin_float(); e.py = fin_float(); e.pz = fin_float();
    e.pf = {1'($urandom), 3'b111};
    step(e);
    e = blank(OP_SHIFT); e.instr = ins(0, r0, r1, SHIFT_AMT); e.v = v; e.v2 = v;
    step(e);
    if ($urandom_range(1)) begin
      e.instr = ins(0, r1, r1, SHIFT_AMT); e.ar = 1;
      step(e);
    end
    if ($urandom_range(2) == 0) begin
      e = blank(OP_COPY); e.ia = r2; e.ib = r1; e.v = v; e.v2 = v;
      step(e);
      r1 = r2;
    end
    if ($urandom_range(3) == 0) begin
      e = blank(OP_OBSERVE); e.ia = r1;
      step(e);
    end
    e = blank(OP_STORE); e.instr = ins(PRIM_SW, r1, 0, 0); e.addr = a; e.v = v;
    step(e);
    if ($urandom_range(3) == 0) begin
      e = blank(OP_LOAD); e.instr = ins(PRIM_LW, 5'($urandom_range(1, 31)), 0, 0);
      e.addr = a; e.v = v;
      step(e);
    end
    if ($urandom_range(9) == 0) begin
      e = blank(OP_MEM_WR); e.addr = a;
      step(e);
    end
    e = blank(OP_FIFO_WR); e.ia = f; e.addr = a; e.v = v;
    step(e);
    e = blank(OP_CB_COPY); e.ia = b; e.ib = f;
    step(e);
    e = blank(OP_RECOVER); e.ia = b; e.v = v;
    step(e);
  endtask

  task automatic directed();
    event_t e;
    // projected vertex in r7, with w; zero register and bad inputs opened too
    e = blank(OP_COP_MOVE); e.instr = ins(0, 0, 0, 0); e.v = 1; e.v2 = 1; e.pf = 4'hf;
    send(e);
    e.instr = ins(6'h3f, 7, 5'h1f, 5'h1f); e.v = 32'hffffffff; e.v2 = 32'hffffffff;
    e.px = 32'h7f7fffff; e.py = 32'h80000000; e.pz = 32'hff7fffff;
    send(e);
    e.instr = ins(0, 8, 0, 0); e.px = 32'h7f800000; send(e);
    e.px = 0; e.pz = 32'hffffffff; send(e);
    e.pz = 0; e.pf = 4'h9; send(e);
    e.pf = 4'h7; e.v2 = 0; send(e);
    // shift with wrong amount, then logical and arithmetic back, and r0 dest
    e = blank(OP_SHIFT); e.instr = ins(0, 7, 9, 4); e.v = 32'hffffffff;
    e.v2 = 32'hffffffff; send(e);
    e.instr = ins(0, 7, 0, SHIFT_AMT); send(e);
    e.instr = ins(0, 7, 9, SHIFT_AMT); e.v = 32'h07ffffff; send(e);
    e.instr = ins(0, 9, 9, SHIFT_AMT); e.ar = 1; e.v2 = 32'h07ffffff;
    e.v = 32'hffffffff; send(e);
    // copy from r0 and a good copy; observe touched then untouched
    e = blank(OP_COPY); e.ia = 10; e.ib = 0; send(e);
    e.ia = 31; e.ib = 9; e.v = 32'hffffffff; e.v2 = 32'hffffffff; send(e);
    e = blank(OP_OBSERVE); e.ia = 10; send(e); send(e);
    e.ia = 0; send(e);
    // store to the last scratch word and the top ram word, unmapped too
    e = blank(OP_STORE); e.instr = ins(PRIM_SW, 31, 0, 0); e.addr = 32'h1f8003ff;
    e.v = 32'hffffffff; send(e);
    e.addr = 32'ha01ffffc; send(e);
    e.addr = 32'h1f800400; send(e);
    e = blank(OP_LOAD); e.instr = ins(PRIM_SW, 3, 0, 0); e.addr = 32'h1f8003fc;
    e.v = 32'hffffffff; send(e);
    e = blank(OP_FIFO_WR); e.ia = 31; e.addr = 32'h1f8003fc; e.v = 32'hffffffff; send(e);
    e = blank(OP_CB_COPY); e.ia = 15; e.ib = 31; send(e);
    e.ia = 16; send(e);
    e = blank(OP_RECOVER); e.ia = 15; e.v = 32'hffffffff; send(e);
    e.ia = 16; send(e);
    for (int k = 10; k < 16; k++) send(blank(4'(k)));
  endtask

  // result side: a long hold-off, a stretch with no gaps, random stalls otherwise
  initial begin
    int cyc;
    cyc = 0;
    do @(posedge clk); while (rst || !s_tready);
    forever begin
      if (cyc >= 400 && cyc < 700) m_tready <= 0;
      else if (cyc >= 1200 && cyc < 1800) m_tready <= 1;
      else m_tready <= $urandom_range(99) >= 6;
      cyc++;
      @(posedge clk);
    end
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed();
    while (sent < 1300) begin
      if ($urandom_range(4) == 0) send(noise());
      else vertex_chain();
    end
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
hdl/vpt_pkg.sv
hdl/vpt_ram.sv
hdl/vertex_provenance_tracker.sv
hdl/vpt_checker.sv
bench/vpt_checker.sv
bench/tb_vertex_provenance_tracker.sv
